// ===== sv/vsr_pkg.sv =====
// ---------------------------------------------------------------------------
// vsr_pkg
// Shared constants, codes and types of the viewport and scissor remapper.
// ---------------------------------------------------------------------------
package vsr_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int SEARCH_SPAN = 4096;
    localparam int SEARCH_STEP = 1024;
    localparam int MAX_EXTENT  = 32767;

    localparam int GRID_N = 2 * SEARCH_SPAN / SEARCH_STEP + 1;
    localparam int IDX_W  = (GRID_N > 1) ? $clog2(GRID_N) : 1;

    localparam int EXT_W = 15;               // extent registers
    localparam int PIX_W = 16;               // pixel fields
    localparam int VP_W  = 24;               // fixed point viewport fields
    localparam int OUT_W = 32;               // mapped viewport fields
    localparam int OFS_W = 18;               // base offset plus shift
    localparam int N_W   = 27;               // scale operand
    localparam int MAG_W = N_W + EXT_W;      // dividend magnitude
    localparam int Q_W   = MAG_W + 1;        // signed quotient
    localparam int CFG_W = 3;

    localparam logic [1:0] ST_MAPPED  = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NATIVE  = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic [1:0] MD_ROUND = 2'd0;
    localparam logic [1:0] MD_FLOOR = 2'd1;
    localparam logic [1:0] MD_CEIL  = 2'd2;

    localparam logic [CFG_W-1:0] REG_LW     = 3'd0;
    localparam logic [CFG_W-1:0] REG_LH     = 3'd1;
    localparam logic [CFG_W-1:0] REG_TW     = 3'd2;
    localparam logic [CFG_W-1:0] REG_TH     = 3'd3;
    localparam logic [CFG_W-1:0] REG_NATIVE = 3'd4;

    typedef struct packed {
        logic                    done;
        logic                    found;
        logic signed [OFS_W-1:0] ox;
        logic signed [OFS_W-1:0] oy;
        logic [EXT_W-1:0]        l;
        logic [EXT_W-1:0]        t;
        logic [EXT_W-1:0]        r;
        logic [EXT_W-1:0]        b;
    } srch_res_t;

endpackage

// ===== sv/vsr_search.sv =====
// ---------------------------------------------------------------------------
// vsr_search
// Offset grid search: one candidate a cycle through a three stage scorer.
// ---------------------------------------------------------------------------
module vsr_search (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [vsr_pkg::PIX_W-1:0] sx,
    input  logic signed [vsr_pkg::PIX_W-1:0] sy,
    input  logic signed [vsr_pkg::PIX_W-1:0] sw,
    input  logic signed [vsr_pkg::PIX_W-1:0] sh,
    input  logic signed [vsr_pkg::PIX_W-1:0] bx,
    input  logic signed [vsr_pkg::PIX_W-1:0] by,
    input  logic signed [vsr_pkg::VP_W-1:0]  vl,
    input  logic signed [vsr_pkg::VP_W-1:0]  vt,
    input  logic signed [vsr_pkg::VP_W-1:0]  vw,
    input  logic signed [vsr_pkg::VP_W-1:0]  vh,
    input  logic [vsr_pkg::EXT_W-1:0]        lw,
    input  logic [vsr_pkg::EXT_W-1:0]        lh,
    output vsr_pkg::srch_res_t               res
);
    import vsr_pkg::*;

    localparam int D_W  = OFS_W + 1;
    localparam int FP_W = D_W + FRAC_BITS;
    localparam int OV_W = EXT_W + FRAC_BITS + 1;
    localparam int SC_W = 2 * OV_W - 2 * FRAC_BITS;

    function automatic logic [EXT_W-1:0] clamp_px(input logic signed [D_W-1:0] v,
                                                 input logic [EXT_W-1:0] hi);
        logic [EXT_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(D_W'(hi)))
            r = hi;
        else
            r = v[EXT_W-1:0];
        return r;
    endfunction

    // pixel span [a, b] moved by ofs, in fixed point, against viewport span
    function automatic logic [OV_W-1:0] overlap(input logic [EXT_W-1:0] a,
                                               input logic [EXT_W-1:0] b,
                                               input logic signed [OFS_W-1:0] ofs,
                                               input logic signed [VP_W-1:0] pos,
                                               input logic signed [VP_W-1:0] len);
        logic signed [FP_W-1:0] a0, a1, e, lo, hi, x0, x1, d;
        a0 = ($signed(FP_W'(a)) + FP_W'(ofs)) <<< FRAC_BITS;
        a1 = ($signed(FP_W'(b)) + FP_W'(ofs)) <<< FRAC_BITS;
        e  = FP_W'(pos) + FP_W'(len);
        lo = (len < 0) ? e : FP_W'(pos);
        hi = (len < 0) ? FP_W'(pos) : e;
        x0 = (a0 < lo) ? lo : ((a0 > hi) ? hi : a0);
        x1 = (a1 < lo) ? lo : ((a1 > hi) ? hi : a1);
        d  = x1 - x0;
        return (x1 > x0) ? d[OV_W-1:0] : '0;
    endfunction

    logic                    run_reg;
    logic [IDX_W-1:0]        ix_reg, iy_reg;
    logic signed [OFS_W-1:0] ox_reg, oy_reg;

    logic [EXT_W-1:0] cl, cr, ct, cb;
    logic             cand_ok, last_issue;
    logic signed [OFS_W-1:0] oy_base;

    // stage a to b
    logic                    a_v_reg, a_last_reg;
    logic [OV_W-1:0]         a_ow_reg, a_oh_reg;
    logic [EXT_W-1:0]        a_l_reg, a_r_reg, a_t_reg, a_b_reg;
    logic signed [OFS_W-1:0] a_ox_reg, a_oy_reg;

    // stage b to c
    logic                    b_v_reg, b_last_reg;
    logic [SC_W-1:0]         b_score_reg;
    logic [2*EXT_W-1:0]      b_area_reg;
    logic [EXT_W-1:0]        b_l_reg, b_r_reg, b_t_reg, b_b_reg;
    logic signed [OFS_W-1:0] b_ox_reg, b_oy_reg;

    logic [2*OV_W-1:0]       prod;
    logic                    better;

    logic                    done_reg, found_reg;
    logic [SC_W-1:0]         best_score_reg;
    logic [2*EXT_W-1:0]      best_area_reg;
    logic signed [OFS_W-1:0] best_ox_reg, best_oy_reg;
    logic [EXT_W-1:0]        bl_reg, br_reg, bt_reg, bb_reg;

    assign oy_base = OFS_W'(by) - OFS_W'(SEARCH_SPAN);

    always_comb
    begin
        cl = clamp_px(D_W'(sx) - D_W'(ox_reg), lw);
        cr = clamp_px(D_W'(sx) + D_W'(sw) - D_W'(ox_reg), lw);
        ct = clamp_px(D_W'(sy) - D_W'(oy_reg), lh);
        cb = clamp_px(D_W'(sy) + D_W'(sh) - D_W'(oy_reg), lh);
        cand_ok = (sw > 0) && (sh > 0) && (cl < cr) && (ct < cb);
        last_issue = (ix_reg == IDX_W'(GRID_N - 1)) && (iy_reg == IDX_W'(GRID_N - 1));
    end

    assign prod = a_ow_reg * a_oh_reg;

    assign better = !found_reg || (b_score_reg > best_score_reg) ||
                    ((b_score_reg == best_score_reg) && (b_area_reg > best_area_reg));

    // candidate sequencer, y inner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            ix_reg  <= '0;
            iy_reg  <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            ix_reg  <= '0;
            iy_reg  <= '0;
        end
        else if (run_reg)
        begin
            if (iy_reg == IDX_W'(GRID_N - 1))
            begin
                iy_reg <= '0;
                ix_reg <= ix_reg + 1'b1;
                if (last_issue)
                    run_reg <= 1'b0;
            end
            else
            begin
                iy_reg <= iy_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ox_reg <= OFS_W'(bx) - OFS_W'(SEARCH_SPAN);
            oy_reg <= oy_base;
        end
        else if (run_reg)
        begin
            if (iy_reg == IDX_W'(GRID_N - 1))
            begin
                oy_reg <= oy_base;
                ox_reg <= ox_reg + OFS_W'(SEARCH_STEP);
            end
            else
            begin
                oy_reg <= oy_reg + OFS_W'(SEARCH_STEP);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            a_last_reg <= 1'b0;
            b_v_reg    <= 1'b0;
            b_last_reg <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            a_v_reg    <= run_reg && cand_ok;
            a_last_reg <= run_reg && last_issue;
            b_v_reg    <= a_v_reg;
            b_last_reg <= a_last_reg;
            done_reg   <= b_last_reg;
            if (start)
                found_reg <= 1'b0;
            else if (b_v_reg && better)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ow_reg <= overlap(cl, cr, ox_reg, vl, vw);
        a_oh_reg <= overlap(ct, cb, oy_reg, vt, vh);
        a_l_reg  <= cl;
        a_r_reg  <= cr;
        a_t_reg  <= ct;
        a_b_reg  <= cb;
        a_ox_reg <= ox_reg;
        a_oy_reg <= oy_reg;

        b_score_reg <= prod[2*OV_W-1:2*FRAC_BITS];
        b_area_reg  <= (a_r_reg - a_l_reg) * (a_b_reg - a_t_reg);
        b_l_reg     <= a_l_reg;
        b_r_reg     <= a_r_reg;
        b_t_reg     <= a_t_reg;
        b_b_reg     <= a_b_reg;
        b_ox_reg    <= a_ox_reg;
        b_oy_reg    <= a_oy_reg;

        if (start)
        begin
            best_ox_reg <= '0;
            best_oy_reg <= '0;
        end
        else if (b_v_reg && better)
        begin
            best_score_reg <= b_score_reg;
            best_area_reg  <= b_area_reg;
            best_ox_reg    <= b_ox_reg;
            best_oy_reg    <= b_oy_reg;
            bl_reg         <= b_l_reg;
            br_reg         <= b_r_reg;
            bt_reg         <= b_t_reg;
            bb_reg         <= b_b_reg;
        end
    end

    always_comb
    begin
        res.done  = done_reg;
        res.found = found_reg;
        res.ox    = best_ox_reg;
        res.oy    = best_oy_reg;
        res.l     = bl_reg;
        res.t     = bt_reg;
        res.r     = br_reg;
        res.b     = bb_reg;
    end

endmodule

// ===== sv/vsr_muldiv.sv =====
// ---------------------------------------------------------------------------
// vsr_muldiv
// Scale unit: n * t / l with round, floor or ceil, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module vsr_muldiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [vsr_pkg::N_W-1:0] n,
    input  logic [vsr_pkg::EXT_W-1:0]      t,
    input  logic [vsr_pkg::EXT_W-1:0]      l,
    input  logic [1:0]                     mode,
    output logic                           done,
    output logic signed [vsr_pkg::Q_W-1:0] q
);
    import vsr_pkg::*;

    localparam logic [1:0] MS_IDLE = 2'd0;
    localparam logic [1:0] MS_MUL  = 2'd1;
    localparam logic [1:0] MS_LOAD = 2'd2;
    localparam logic [1:0] MS_DIV  = 2'd3;
    localparam int CNT_W = $clog2(MAG_W);

    logic [1:0]              state_reg;
    logic signed [N_W-1:0]   n_reg;
    logic [EXT_W-1:0]        t_reg, l_reg;
    logic [1:0]              mode_reg;
    logic signed [Q_W-1:0]   prod_reg;
    logic [MAG_W-1:0]        dvd_reg;
    logic [EXT_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg, done_reg;

    logic [Q_W-1:0]          mag;
    logic [MAG_W-1:0]        bias;
    logic [EXT_W:0]          trial;
    logic                    fits;

    always_comb
    begin
        mag = (prod_reg < 0) ? Q_W'(-prod_reg) : Q_W'(prod_reg);
        case (mode_reg)
            MD_ROUND: bias = MAG_W'(l_reg >> 1);
            MD_CEIL:  bias = MAG_W'(l_reg) - MAG_W'(1);
            default:  bias = '0;
        endcase
        trial = {rem_reg, dvd_reg[MAG_W-1]};
        fits  = trial >= {1'b0, l_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MS_IDLE: if (start) state_reg <= MS_MUL;
                MS_MUL:  state_reg <= MS_LOAD;
                MS_LOAD: state_reg <= MS_DIV;
                MS_DIV:
                begin
                    if (cnt_reg == CNT_W'(MAG_W - 1))
                    begin
                        state_reg <= MS_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= MS_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MS_IDLE && start)
        begin
            n_reg    <= n;
            t_reg    <= t;
            l_reg    <= l;
            mode_reg <= mode;
        end
        if (state_reg == MS_MUL)
            prod_reg <= n_reg * $signed({1'b0, t_reg});
        if (state_reg == MS_LOAD)
        begin
            dvd_reg <= mag[MAG_W-1:0] + bias;
            neg_reg <= prod_reg < 0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (state_reg == MS_DIV)
        begin
            // remainder stays below l, so it fits the extent width
            rem_reg <= fits ? EXT_W'(trial - {1'b0, l_reg}) : trial[EXT_W-1:0];
            dvd_reg <= {dvd_reg[MAG_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});

endmodule

// ===== sv/viewport_scissor_remapper_top.sv =====
// ---------------------------------------------------------------------------
// viewport_scissor_remapper_top
// Maps a logical viewport and scissor into render target space.
// ---------------------------------------------------------------------------
// One item is worked at a time and s_tready is low until its result is loaded
// into the output register. Invalid extents and native mode go straight to the
// output stage. A mapped item runs the 81 point offset grid through the scorer,
// one candidate a cycle, then eight scale operations on the shared multiply and
// divide unit, each working out its 42 quotient bits.
module viewport_scissor_remapper_top
    import vsr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // vp_left, vp_top, vp_width, vp_height, scissor_x, scissor_y, scissor_w,
    // scissor_h, offset_x, offset_y
    input  logic [191:0]            s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // out_left, out_top, out_width, out_height, clip_left, clip_top,
    // clip_width, clip_height
    output logic [191:0]            m_tdata,
    // status
    output logic [1:0]              m_tuser,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_addr,
    input  logic [EXT_W-1:0]        cfg_wdata
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_SC_GO   = 3'd2;
    localparam logic [2:0] S_SC_WAIT = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [EXT_W-1:0] lw_reg, lh_reg, tw_reg, th_reg;
    logic             native_reg;

    logic [2:0] state_reg;
    logic [2:0] op_reg;
    logic [1:0] status_reg;
    logic       srch_go_reg;

    logic signed [VP_W-1:0]  vl_reg, vt_reg, vw_reg, vh_reg;
    logic signed [PIX_W-1:0] sx_reg, sy_reg, sw_reg, sh_reg, bx_reg, by_reg;

    logic [OUT_W-1:0] vp_res_reg [4];
    logic [EXT_W-1:0] px_res_reg [4];

    logic              m_tvalid_reg;
    logic [191:0]      m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    logic              accept, bad_ext, srch_start, md_start, md_done, out_free;
    srch_res_t         srch;
    logic signed [N_W-1:0] md_n;
    logic [EXT_W-1:0]  md_t, md_l;
    logic [1:0]        md_mode;
    logic signed [Q_W-1:0] md_q;
    logic [191:0]      out_data;

    function automatic logic [OUT_W-1:0] sat32(input logic signed [Q_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (&v[Q_W-1:OUT_W-1] || ~|v[Q_W-1:OUT_W-1])
            r = v[OUT_W-1:0];
        else
            r = v[Q_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        return r;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;
    assign bad_ext  = (lw_reg == '0) || (lh_reg == '0) || (tw_reg == '0) || (th_reg == '0) ||
                      (32'(lw_reg) > MAX_EXTENT) || (32'(lh_reg) > MAX_EXTENT) ||
                      (32'(tw_reg) > MAX_EXTENT) || (32'(th_reg) > MAX_EXTENT);
    assign srch_start = accept && !bad_ext && !native_reg;
    assign md_start   = state_reg == S_SC_GO;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg     <= EXT_W'(640);
            lh_reg     <= EXT_W'(480);
            tw_reg     <= EXT_W'(640);
            th_reg     <= EXT_W'(480);
            native_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LW:     lw_reg     <= cfg_wdata;
                REG_LH:     lh_reg     <= cfg_wdata;
                REG_TW:     tw_reg     <= cfg_wdata;
                REG_TH:     th_reg     <= cfg_wdata;
                REG_NATIVE: native_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vl_reg <= s_tdata[23:0];
            vt_reg <= s_tdata[47:24];
            vw_reg <= s_tdata[71:48];
            vh_reg <= s_tdata[95:72];
            sx_reg <= s_tdata[111:96];
            sy_reg <= s_tdata[127:112];
            sw_reg <= s_tdata[143:128];
            sh_reg <= s_tdata[159:144];
            bx_reg <= s_tdata[175:160];
            by_reg <= s_tdata[191:176];
        end
        if (state_reg == S_SC_WAIT && md_done)
        begin
            // viewport operations first, then the scissor edges
            if (!op_reg[2])
                vp_res_reg[op_reg[1:0]] <= sat32(md_q);
            else
                px_res_reg[op_reg[1:0]] <= md_q[EXT_W-1:0];
        end
    end

    // the search reads the item registers, so its start is registered from the accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            srch_go_reg <= 1'b0;
        else
            srch_go_reg <= srch_start;
    end

    vsr_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (srch_go_reg),
        .sx    (sx_reg),
        .sy    (sy_reg),
        .sw    (sw_reg),
        .sh    (sh_reg),
        .bx    (bx_reg),
        .by    (by_reg),
        .vl    (vl_reg),
        .vt    (vt_reg),
        .vw    (vw_reg),
        .vh    (vh_reg),
        .lw    (lw_reg),
        .lh    (lh_reg),
        .res   (srch)
    );

    always_comb
    begin
        unique case (op_reg)
            3'd0:
            begin
                md_n = N_W'(vl_reg) - (N_W'(srch.ox) <<< FRAC_BITS);
                md_t = tw_reg; md_l = lw_reg; md_mode = MD_ROUND;
            end
            3'd1:
            begin
                md_n = N_W'(vt_reg) - (N_W'(srch.oy) <<< FRAC_BITS);
                md_t = th_reg; md_l = lh_reg; md_mode = MD_ROUND;
            end
            3'd2:
            begin
                md_n = N_W'(vw_reg); md_t = tw_reg; md_l = lw_reg; md_mode = MD_ROUND;
            end
            3'd3:
            begin
                md_n = N_W'(vh_reg); md_t = th_reg; md_l = lh_reg; md_mode = MD_ROUND;
            end
            3'd4:
            begin
                md_n = $signed(N_W'(srch.l)); md_t = tw_reg; md_l = lw_reg; md_mode = MD_FLOOR;
            end
            3'd5:
            begin
                md_n = $signed(N_W'(srch.t)); md_t = th_reg; md_l = lh_reg; md_mode = MD_FLOOR;
            end
            3'd6:
            begin
                md_n = $signed(N_W'(srch.r)); md_t = tw_reg; md_l = lw_reg; md_mode = MD_CEIL;
            end
            default:
            begin
                md_n = $signed(N_W'(srch.b)); md_t = th_reg; md_l = lh_reg; md_mode = MD_CEIL;
            end
        endcase
    end

    vsr_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .n     (md_n),
        .t     (md_t),
        .l     (md_l),
        .mode  (md_mode),
        .done  (md_done),
        .q     (md_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= '0;
            status_reg <= ST_MAPPED;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (bad_ext)
                        begin
                            status_reg <= ST_INVALID;
                            state_reg  <= S_DONE;
                        end
                        else if (native_reg)
                        begin
                            status_reg <= ST_NATIVE;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (srch.done)
                    begin
                        status_reg <= srch.found ? ST_MAPPED : ST_NONE;
                        op_reg     <= '0;
                        state_reg  <= S_SC_GO;
                    end
                end
                S_SC_GO: state_reg <= S_SC_WAIT;
                S_SC_WAIT:
                begin
                    if (md_done)
                    begin
                        op_reg    <= op_reg + 1'b1;
                        state_reg <= (op_reg == 3'd7) ? S_DONE : S_SC_GO;
                    end
                end
                S_DONE: if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        out_data = '0;
        if (status_reg == ST_INVALID || status_reg == ST_NATIVE)
        begin
            out_data[31:0]   = OUT_W'(vl_reg);
            out_data[63:32]  = OUT_W'(vt_reg);
            out_data[95:64]  = OUT_W'(vw_reg);
            out_data[127:96] = OUT_W'(vh_reg);
        end
        else
        begin
            out_data[31:0]   = vp_res_reg[0];
            out_data[63:32]  = vp_res_reg[1];
            out_data[95:64]  = vp_res_reg[2];
            out_data[127:96] = vp_res_reg[3];
        end
        if (status_reg == ST_NATIVE)
        begin
            out_data[143:128] = sx_reg;
            out_data[159:144] = sy_reg;
            out_data[175:160] = sw_reg;
            out_data[191:176] = sh_reg;
        end
        else if (status_reg == ST_MAPPED)
        begin
            // right and bottom edges become width and height
            out_data[143:128] = PIX_W'(px_res_reg[0]);
            out_data[159:144] = PIX_W'(px_res_reg[1]);
            out_data[175:160] = PIX_W'(px_res_reg[2]) - PIX_W'(px_res_reg[0]);
            out_data[191:176] = PIX_W'(px_res_reg[3]) - PIX_W'(px_res_reg[1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== sv/vsr_checker.sv =====
// ---------------------------------------------------------------------------
// vsr_checker
// Port level checks of the remapper, bound to the top level.
// ---------------------------------------------------------------------------
module vsr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import vsr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // invalid extent and no candidate give an empty scissor
    a_empty_clip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_INVALID || m_tuser == ST_NONE) |-> m_tdata[191:128] == '0)
        else $error("scissor not empty");

    // a mapped scissor never has negative size
    a_mapped_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_MAPPED |-> !m_tdata[175] && !m_tdata[191])
        else $error("negative scissor size");

endmodule

bind viewport_scissor_remapper_top vsr_checker u_vsr_checker (.*);
